// ----- sv/servo_slew_limiter_with_override_defines.svh -----
// Assertion macros for the servo slew limiter.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SERVO_SLEW_LIMITER_WITH_OVERRIDE_DEFINES_SVH
`define SERVO_SLEW_LIMITER_WITH_OVERRIDE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SSL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define SSL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ssl_pkg.sv -----
// Package for the servo slew limiter: state machine type, per-channel
// memory entry, request codes, register map and fixed-point constants.
// No dependencies.
package ssl_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_RECIP,
		ST_FIX1,
		ST_FIX2,
		ST_MOVE,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [11:0]        live_target;
		logic [31:0]        live_expiry;
		logic [31:0]        last_ms;
		logic signed [13:0] angle;
	} entry_t;

	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_SET    = 2'd1;
	localparam logic [1:0] ACT_STOP   = 2'd2;

	localparam logic [2:0] REG_MANUAL_MASK   = 3'd0;
	localparam logic [2:0] REG_MANUAL_ANGLES = 3'd1;
	localparam logic [2:0] REG_MAX_SPEEDS    = 3'd2;
	localparam logic [2:0] REG_MAX_ANGLES    = 3'd3;
	localparam logic [2:0] REG_LIVE_TTL      = 3'd4;

	localparam logic [47:0] MAX_ANGLES_RST = 48'hB40B40B40B40;
	localparam logic [15:0] LIVE_TTL_RST   = 16'd1000;

	localparam logic [11:0] LIVE_MAX = 12'd2880;
	localparam logic [23:0] TICKS_DIV = 24'd625;
	// floor(2^34 / 625); exact within one for numerators below 2^24
	localparam logic [24:0] RECIP_M  = 25'd27487790;
	localparam int          RECIP_SH = 34;
	localparam int          DIV_BITS = 24;

endpackage

// ----- sv/servo_slew_limiter_with_override.sv -----
// Servo slew limiter with timed live override, four channels of state in one
// synchronous memory. An update runs from acceptance through one memory read,
// five arithmetic steps, a 24-step restoring divider for the achieved speed and
// the result load, then returns to idle to take the next request; no new request
// is taken before that. A result load also waits while the previous result still
// sits unaccepted in the output register. Live set and live stop run through the
// memory read and return to idle; a request for an out-of-range channel or an
// unknown action is dropped on acceptance. The result sits in an output register,
// so a new request is taken while it waits for m_tready.
// Configuration registers sit at byte addresses 0, 8, 16, 24 and 32 (64-bit).
module servo_slew_limiter_with_override
	import ssl_pkg::*;
#(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [2:0] channel, [16:3] angle, [48:17] now_ms, rest zero
	input  logic [55:0] s_tdata,
	// [1:0] action
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] out_channel, [15:2] target_angle, [29:16] current_angle,
	// [45:30] speed_dps, [46] drive_on, [56:47] drive_degrees, rest zero
	output logic [63:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W = $clog2(DIV_BITS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_BITS - 1);

	logic [3:0]  manual_mask_q;
	logic [47:0] manual_angles_q;
	logic [47:0] max_speeds_q;
	logic [47:0] max_angles_q;
	logic [15:0] live_ttl_q;

	state_t state_q, state_d;

	entry_t mem [CHANNELS];
	entry_t rd_q;
	entry_t wr_entry;
	logic   mem_we;

	logic [CHANNELS-1:0] flag_q;
	logic [CHANNELS-1:0] init_q;
	logic                vld_q;

	logic [1:0]         act_q;
	logic [2:0]         ch_q;
	logic signed [13:0] ang_q;
	logic [31:0]        now_q;

	logic signed [13:0] tgt_q;
	logic signed [13:0] prev_q;
	logic [35:0]        dt10_q;
	logic [13:0]        mag_q;
	logic               up_q;
	logic [47:0]        prod_q;
	logic [23:0]        mag625_q;
	logic               lim_q;
	logic [48:0]        recip_q;
	logic [14:0]        q0_q;
	logic [23:0]        q625_q;
	logic [14:0]        step_q;
	logic signed [13:0] cur_q;
	logic [35:0]        rem_q;
	logic [23:0]        quo_q;
	logic [CNT_W-1:0]   cnt_q;

	logic        m_tvalid_q;
	logic [63:0] m_tdata_q;

	logic        accept, take, cfg_we, out_load;
	logic [2:0]  in_chan;
	logic [1:0]  in_act;
	logic [CH_W-1:0] idx;

	logic [31:0]        last_ms;
	logic signed [13:0] prev;
	logic               live_on;
	logic signed [13:0] tgt;
	logic [31:0]        dt;
	logic [35:0]        dt10;
	logic signed [14:0] diff;
	logic [11:0]        live_clamp;
	logic signed [14:0] cur_wide;
	logic [13:0]        dmag;
	logic [36:0]        trial;
	logic               trial_ok;
	logic [1:0]         ch2;
	logic signed [14:0] open_lim;
	logic               drive;
	logic signed [14:0] deg_wide;
	logic [9:0]         degrees;
	logic [15:0]        speed;

	assign in_chan = s_tdata[2:0];
	assign in_act  = s_tuser;
	assign accept  = s_tvalid && s_tready;
	assign take    = accept && (int'(in_chan) < CHANNELS) &&
		(in_act == ACT_UPDATE || in_act == ACT_SET || in_act == ACT_STOP);
	assign idx     = ch_q[CH_W-1:0];
	assign ch2     = ch_q[1:0];

	// configuration port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manual_mask_q   <= '0;
			manual_angles_q <= '0;
			max_speeds_q    <= '0;
			max_angles_q    <= MAX_ANGLES_RST;
			live_ttl_q      <= LIVE_TTL_RST;
		end else if (cfg_we) begin
			case (paddr[5:3])
				REG_MANUAL_MASK:   manual_mask_q   <= pwdata[3:0];
				REG_MANUAL_ANGLES: manual_angles_q <= pwdata[47:0];
				REG_MAX_SPEEDS:    max_speeds_q    <= pwdata[47:0];
				REG_MAX_ANGLES:    max_angles_q    <= pwdata[47:0];
				REG_LIVE_TTL:      live_ttl_q      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[5:3])
			REG_MANUAL_MASK:   prdata = {60'd0, manual_mask_q};
			REG_MANUAL_ANGLES: prdata = {16'd0, manual_angles_q};
			REG_MAX_SPEEDS:    prdata = {16'd0, max_speeds_q};
			REG_MAX_ANGLES:    prdata = {16'd0, max_angles_q};
			REG_LIVE_TTL:      prdata = {48'd0, live_ttl_q};
			default:           prdata = '0;
		endcase
	end

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (take) state_d = ST_READ;
			ST_READ:  state_d = (act_q == ACT_UPDATE) ? ST_MUL : ST_IDLE;
			ST_MUL:   state_d = ST_RECIP;
			ST_RECIP: state_d = ST_FIX1;
			ST_FIX1:  state_d = ST_FIX2;
			ST_FIX2:  state_d = ST_MOVE;
			ST_MOVE:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == DIV_LAST) state_d = ST_OUT;
			ST_OUT:   if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mem_we   = ((state_q == ST_READ) && (act_q != ACT_UPDATE)) || (state_q == ST_MOVE);
		out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= in_act;
			ch_q  <= in_chan;
			ang_q <= s_tdata[16:3];
			now_q <= s_tdata[48:17];
		end
	end

	// channel memory
	always_ff @(posedge clk) begin
		if (take) begin
			rd_q <= mem[in_chan[CH_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			vld_q  <= 1'b0;
			flag_q <= '0;
		end else begin
			if (take) vld_q <= init_q[in_chan[CH_W-1:0]];
			if (mem_we) init_q[idx] <= 1'b1;
			if (state_q == ST_READ) begin
				unique case (act_q)
					ACT_SET:  flag_q[idx] <= 1'b1;
					ACT_STOP: flag_q[idx] <= 1'b0;
					default:  flag_q[idx] <= live_on;
				endcase
			end
		end
	end

	// target selection and time step
	always_comb begin
		last_ms = vld_q ? rd_q.last_ms : 32'd0;
		prev    = vld_q ? rd_q.angle : 14'sd0;
		live_on = flag_q[idx] && (now_q <= rd_q.live_expiry);
		if (live_on) begin
			tgt = $signed({2'b00, rd_q.live_target});
		end else if (manual_mask_q[ch2]) begin
			tgt = $signed({2'b00, manual_angles_q[12*ch2 +: 12]});
		end else begin
			tgt = ang_q;
		end
		dt   = now_q - last_ms;
		dt10 = (dt == 32'd0) ? 36'd1 : ({4'd0, dt} << 3) + ({4'd0, dt} << 1);
		diff = 15'(tgt) - 15'(prev);
		if (ang_q < 14'sd0) begin
			live_clamp = 12'd0;
		end else if (ang_q > $signed({2'b00, LIVE_MAX})) begin
			live_clamp = LIVE_MAX;
		end else begin
			live_clamp = ang_q[11:0];
		end
	end

	// new angle
	always_comb begin
		if (!lim_q) begin
			cur_wide = 15'(tgt_q);
		end else if (up_q) begin
			cur_wide = 15'(prev_q) + $signed(step_q);
		end else begin
			cur_wide = 15'(prev_q) - $signed(step_q);
		end
		dmag = lim_q ? step_q[13:0] : mag_q;
	end

	always_comb begin
		wr_entry = rd_q;
		if (state_q == ST_MOVE) begin
			wr_entry.last_ms = now_q;
			wr_entry.angle   = cur_wide[13:0];
		end else begin
			wr_entry.last_ms = last_ms;
			wr_entry.angle   = prev;
			if (act_q == ACT_SET) begin
				wr_entry.live_target = live_clamp;
				wr_entry.live_expiry = now_q + {16'd0, live_ttl_q};
			end else begin
				wr_entry.live_expiry = 32'd0;
			end
		end
	end

	// arithmetic datapath
	assign trial    = {rem_q, quo_q[DIV_BITS-1]};
	assign trial_ok = (trial >= {1'b0, dt10_q});

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_READ: begin
				tgt_q  <= tgt;
				prev_q <= prev;
				dt10_q <= dt10;
				mag_q  <= diff[14] ? 14'(-diff) : diff[13:0];
				up_q   <= !diff[14];
			end
			ST_MUL: begin
				prod_q   <= 48'(max_speeds_q[12*ch2 +: 12]) * 48'(dt10_q);
				mag625_q <= 24'(mag_q) * TICKS_DIV;
			end
			ST_RECIP: begin
				lim_q   <= ({24'd0, mag625_q} > prod_q);
				recip_q <= 49'(prod_q[23:0]) * 49'(RECIP_M);
			end
			ST_FIX1: begin
				q0_q   <= recip_q[48:RECIP_SH];
				q625_q <= 24'(recip_q[48:RECIP_SH]) * TICKS_DIV;
			end
			ST_FIX2: begin
				step_q <= q0_q + 15'((prod_q[23:0] - q625_q) >= TICKS_DIV);
			end
			ST_MOVE: begin
				cur_q <= cur_wide[13:0];
				quo_q <= 24'(dmag) * TICKS_DIV;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= trial_ok ? 36'(trial - {1'b0, dt10_q}) : trial[35:0];
				quo_q <= {quo_q[DIV_BITS-2:0], trial_ok};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// result
	always_comb begin
		open_lim = $signed({3'b000, max_angles_q[12*ch2 +: 12]}) - 15'sd16;
		drive    = !(15'(cur_q) >= open_lim);
		deg_wide = (15'(cur_q) + (cur_q[13] ? 15'sd15 : 15'sd0)) >>> 4;
		degrees  = drive ? deg_wide[9:0] : 10'd0;
		speed    = (quo_q[23:16] != 8'd0) ? 16'hFFFF : quo_q[15:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {7'd0, degrees, drive, speed, cur_q, tgt_q, ch2};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "servo_slew_limiter_with_override_defines.svh"

	`SSL_ASSERT_NOW(a_detach_zero, m_tvalid && !m_tdata[46], m_tdata[56:47] == 10'd0,
		"detached result carries nonzero degrees")
	`SSL_ASSERT_NEXT(a_div_done, (state_q == ST_DIV) && (cnt_q == DIV_LAST),
		state_q == ST_OUT, "divider did not hand over to result stage")
	`SSL_ASSERT_NEXT(a_one_write, mem_we, !mem_we, "two memory writes for one request")

endmodule
